[sv/ptts_pkg.sv]
package ptts_pkg;

    // Default sizing of the task table.
    localparam int NUM_TASKS_DEF  = 8;
    localparam int COUNT_BITS_DEF = 16;

    // Width of the fire mask reported on a tick.
    localparam int FIRE_W = 8;

    // Command codes.
    localparam logic [2:0] CMD_TICK    = 3'd0;
    localparam logic [2:0] CMD_CREATE  = 3'd1;
    localparam logic [2:0] CMD_DELETE  = 3'd2;
    localparam logic [2:0] CMD_SUSPEND = 3'd3;
    localparam logic [2:0] CMD_RESUME  = 3'd4;

    // Status codes.
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_RANGE = 2'd1;
    localparam logic [1:0] STAT_USED  = 2'd2;
    localparam logic [1:0] STAT_EMPTY = 2'd3;

    // Input transaction payload.
    typedef struct packed {
        logic [2:0]  cmd;
        logic [5:0]  slot;
        logic [15:0] period;
        logic [15:0] first_delay;
    } ptts_in_t;

    // Result transaction payload.
    typedef struct packed {
        logic [1:0]        status;
        logic [FIRE_W-1:0] fire_mask;
    } ptts_out_t;

endpackage

[sv/ptts_ram.sv]
module ptts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                        aclk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/periodic_task_table_scheduler_unit.sv]
// Create, delete, suspend and resume go from S_IDLE to S_DONE, which loads the result
// and raises m_valid. A tick walks the slot memory one slot per cycle in S_WALK before
// S_DONE. One transaction at a time: a new one is taken the cycle after the result is
// loaded, and S_DONE waits while a result not yet taken holds the output register.
// Reset (aresetn low, synchronous) empties every slot; the memory needs no clearing pass.
module periodic_task_table_scheduler_unit
    import ptts_pkg::*;
#(
    parameter int NUM_TASKS  = NUM_TASKS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  ptts_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output ptts_out_t m_data
);

    localparam int ADDR_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int CNT_W  = $clog2(NUM_TASKS + 1);
    localparam int WORD_W = 2 * COUNT_BITS;

    // Controller states.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic [NUM_TASKS-1:0] valid_reg, valid_next;
    logic [NUM_TASKS-1:0] run_reg, run_next;
    logic [CNT_W-1:0]     rd_cnt_reg, rd_cnt_next;
    logic                 wb_vld_reg, wb_vld_next;
    logic [ADDR_W-1:0]    wb_idx_reg, wb_idx_next;
    logic [FIRE_W-1:0]    mask_reg, mask_next;
    logic [1:0]           status_reg, status_next;
    logic                 m_valid_reg, m_valid_next;
    ptts_out_t            m_data_reg, m_data_next;

    logic                 accept;
    logic                 in_range;
    logic [ADDR_W-1:0]    sidx;
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [WORD_W-1:0]    ram_wdata;
    logic                 ram_re;
    logic [ADDR_W-1:0]    ram_raddr;
    logic [WORD_W-1:0]    ram_rdata;
    logic [COUNT_BITS-1:0] rd_period;
    logic [COUNT_BITS-1:0] rd_count;
    logic [6:0]           wb_idx_ext;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == S_IDLE);
    assign in_range  = ({1'b0, s_data.slot} < 7'(NUM_TASKS));
    assign sidx      = s_data.slot[ADDR_W-1:0];
    assign rd_period = ram_rdata[WORD_W-1:COUNT_BITS];
    assign rd_count  = ram_rdata[COUNT_BITS-1:0];
    assign wb_idx_ext = 7'(wb_idx_reg);

    // Period and countdown of every slot live in one word of the slot memory.
    ptts_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_TASKS)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Command handling, tick walk and result hand-off.
    always_comb begin
        state_next   = state_reg;
        valid_next   = valid_reg;
        run_next     = run_reg;
        rd_cnt_next  = rd_cnt_reg;
        wb_vld_next  = 1'b0;
        wb_idx_next  = wb_idx_reg;
        mask_next    = mask_reg;
        status_next  = status_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        ram_we       = 1'b0;
        ram_waddr    = sidx;
        ram_wdata    = {COUNT_BITS'(s_data.period), COUNT_BITS'(s_data.first_delay)};
        ram_re       = 1'b0;
        ram_raddr    = rd_cnt_reg[ADDR_W-1:0];

        // The result register drains independently of the command side.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    mask_next   = '0;
                    status_next = STAT_OK;
                    state_next  = S_DONE;
                    case (s_data.cmd)
                        CMD_TICK: begin
                            rd_cnt_next = '0;
                            state_next  = S_WALK;
                        end
                        CMD_CREATE: begin
                            if (!in_range) begin
                                status_next = STAT_RANGE;
                            end else if (valid_reg[sidx]) begin
                                status_next = STAT_USED;
                            end else begin
                                valid_next[sidx] = 1'b1;
                                run_next[sidx]   = 1'b1;
                                ram_we           = 1'b1;
                            end
                        end
                        CMD_DELETE, CMD_SUSPEND, CMD_RESUME: begin
                            if (!in_range) begin
                                status_next = STAT_RANGE;
                            end else if (!valid_reg[sidx]) begin
                                status_next = STAT_EMPTY;
                            end else if (s_data.cmd == CMD_DELETE) begin
                                valid_next[sidx] = 1'b0;
                                run_next[sidx]   = 1'b0;
                            end else begin
                                run_next[sidx] = (s_data.cmd == CMD_RESUME);
                            end
                        end
                        default: begin
                            status_next = STAT_OK;
                        end
                    endcase
                end
            end

            S_WALK: begin
                // Issue one slot read per cycle.
                if (rd_cnt_reg < CNT_W'(NUM_TASKS)) begin
                    ram_re      = 1'b1;
                    wb_vld_next = 1'b1;
                    wb_idx_next = rd_cnt_reg[ADDR_W-1:0];
                    rd_cnt_next = rd_cnt_reg + CNT_W'(1);
                end else begin
                    state_next = S_DONE;
                end
                // Write back the slot read in the previous cycle.
                if (wb_vld_reg && valid_reg[wb_idx_reg] && run_reg[wb_idx_reg]) begin
                    ram_we    = 1'b1;
                    ram_waddr = wb_idx_reg;
                    if (rd_count == '0) begin
                        ram_wdata = {rd_period, rd_period};
                        for (int j = 0; j < FIRE_W; j++) begin
                            if (wb_idx_ext == 7'(j)) begin
                                mask_next[j] = 1'b1;
                            end
                        end
                    end else begin
                        ram_wdata = {rd_period, rd_count - COUNT_BITS'(1)};
                    end
                end
            end

            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next          = 1'b1;
                    m_data_next.status    = status_reg;
                    m_data_next.fire_mask = mask_reg;
                    state_next            = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state is cleared by reset; payload registers are not.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            valid_reg   <= '0;
            run_reg     <= '0;
            rd_cnt_reg  <= '0;
            wb_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            run_reg     <= run_next;
            rd_cnt_reg  <= rd_cnt_next;
            wb_vld_reg  <= wb_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        wb_idx_reg <= wb_idx_next;
        mask_reg   <= mask_next;
        status_reg <= status_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
